### design/theremin_control_conditioner_macros.svh
// assertion macros used by the checker file of the control conditioner
`ifndef THEREMIN_CONTROL_CONDITIONER_MACROS_SVH
`define THEREMIN_CONTROL_CONDITIONER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("control conditioner check failed");

// next-cycle implication, disabled while reset is low
`define TCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("control conditioner check failed");

`endif

### design/tcc_pkg.sv
// shared types, constants and a helper function of the control conditioner
package tcc_pkg;

    // field widths
    localparam int unsigned POT_W   = 10;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CEIL_W  = 13;
    localparam int unsigned SMOOTH_W = 17;
    localparam int unsigned ADV_W   = 17;
    localparam int unsigned VOL_W   = 16;
    localparam int unsigned WAVE_W  = 3;
    localparam int unsigned OCT_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_BASE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POT_HYSTERESIS = 3'd3;

    // register reset values
    localparam logic [CEIL_W-1:0] CEILING_RESET    = 13'd4095;
    localparam logic [POT_W-1:0]  HYSTERESIS_RESET = 10'd40;

    // octave thresholds and shift codes
    localparam logic [POT_W-1:0] OCT_HIGH_THRESH = 10'd681;
    localparam logic [POT_W-1:0] OCT_LOW_THRESH  = 10'd342;
    localparam logic [OCT_W-1:0] OCT_UP     = 2'd1;
    localparam logic [OCT_W-1:0] OCT_CENTRE = 2'd2;
    localparam logic [OCT_W-1:0] OCT_DOWN   = 2'd3;

    // arithmetic constants
    localparam logic signed [18:0] PITCH_OFFSET = 19'sd2048;
    localparam logic [COUNT_W-1:0] VOLUME_FLOOR = 16'd5000;
    localparam logic signed [18:0] VOLUME_POT_OFFSET = 19'sd1024;
    localparam logic signed [18:0] VOLUME_MAX = 19'sd4095;

    // configuration registers
    typedef struct packed {
        logic [COUNT_W-1:0] pitch_base;
        logic [COUNT_W-1:0] volume_base;
        logic [CEIL_W-1:0]  volume_ceiling;
        logic [POT_W-1:0]   pot_hysteresis;
    } t_cfg;

    // one input item
    typedef struct packed {
        logic [POT_W-1:0]   pitch_trim;
        logic [POT_W-1:0]   volume_trim;
        logic [POT_W-1:0]   octave_pot;
        logic [POT_W-1:0]   wave_pot;
        logic               pitch_present;
        logic [COUNT_W-1:0] pitch_count;
        logic               volume_present;
        logic [COUNT_W-1:0] volume_count;
        logic               muted;
    } t_item;

    // one result item
    typedef struct packed {
        logic signed [ADV_W-1:0] sample_advance;
        logic                    advance_valid;
        logic [VOL_W-1:0]        scaled_volume;
        logic                    volume_valid;
        logic [WAVE_W-1:0]       wave_select;
        logic [OCT_W-1:0]        octave_code;
    } t_result;

    // quarter-step smoother: s + ((x - s) >>> 2)
    function automatic logic signed [SMOOTH_W-1:0] f_smooth(
        input logic signed [SMOOTH_W-1:0] s,
        input logic [COUNT_W-1:0]         x
    );
        logic signed [18:0] diff;
        logic signed [18:0] step;
        diff = $signed({3'b000, x}) - $signed({{2{s[SMOOTH_W-1]}}, s});
        step = diff >>> 2;
        return s + step[SMOOTH_W-1:0];
    endfunction

endpackage

### design/tcc_core.sv
// per-item arithmetic and the smoother and hysteresis state
module tcc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tcc_pkg::t_cfg   i_cfg,
    input  tcc_pkg::t_item  i_item,
    output tcc_pkg::t_result o_result
);

    logic signed [tcc_pkg::SMOOTH_W-1:0] r_pitch_smoothed, n_pitch_smoothed;
    logic signed [tcc_pkg::SMOOTH_W-1:0] r_volume_smoothed, n_volume_smoothed;
    logic [tcc_pkg::POT_W-1:0]           r_wave_held, n_wave_held;

    logic [tcc_pkg::POT_W-1:0]     wave_diff;
    logic [tcc_pkg::OCT_W-1:0]     octave;
    logic signed [18:0]            adv_sum;
    logic signed [18:0]            adv_shifted;
    logic [tcc_pkg::COUNT_W-1:0]   vol_floored;
    logic signed [18:0]            vol_diff;
    logic signed [18:0]            vol_half;
    logic signed [18:0]            vol_raw;
    logic [11:0]                   vol_clamped;
    logic [7:0]                    vol_t;
    logic [8:0]                    vol_t_p2;

    // wave pot hysteresis
    always_comb begin
        if (i_item.wave_pot >= r_wave_held) begin
            wave_diff = i_item.wave_pot - r_wave_held;
        end else begin
            wave_diff = r_wave_held - i_item.wave_pot;
        end
        n_wave_held = (wave_diff >= i_cfg.pot_hysteresis) ? i_item.wave_pot : r_wave_held;
    end

    // octave code from the octave pot
    always_comb begin
        priority if (i_item.octave_pot > tcc_pkg::OCT_HIGH_THRESH) begin
            octave = tcc_pkg::OCT_UP;
        end else if (i_item.octave_pot < tcc_pkg::OCT_LOW_THRESH) begin
            octave = tcc_pkg::OCT_DOWN;
        end else begin
            octave = tcc_pkg::OCT_CENTRE;
        end
    end

    // pitch smoother and sample advance
    always_comb begin
        n_pitch_smoothed = i_item.pitch_present
                         ? tcc_pkg::f_smooth(r_pitch_smoothed, i_item.pitch_count)
                         : r_pitch_smoothed;
        adv_sum = $signed({3'b000, i_cfg.pitch_base})
                - $signed({{2{n_pitch_smoothed[tcc_pkg::SMOOTH_W-1]}}, n_pitch_smoothed})
                + tcc_pkg::PITCH_OFFSET
                - $signed({7'b0, i_item.pitch_trim, 2'b00});
        adv_shifted = adv_sum >>> octave;
    end

    // volume floor, smoother, offset and clamp
    always_comb begin
        vol_floored = (i_item.volume_count < tcc_pkg::VOLUME_FLOOR)
                    ? tcc_pkg::VOLUME_FLOOR : i_item.volume_count;
        n_volume_smoothed = i_item.volume_present
                          ? tcc_pkg::f_smooth(r_volume_smoothed, vol_floored)
                          : r_volume_smoothed;
        vol_diff = $signed({3'b000, i_cfg.volume_base})
                 - $signed({{2{n_volume_smoothed[tcc_pkg::SMOOTH_W-1]}}, n_volume_smoothed});
        // halve, truncating toward zero
        vol_half = (vol_diff + $signed({18'b0, vol_diff[18]})) >>> 1;
        vol_raw  = $signed({6'b0, i_cfg.volume_ceiling}) - vol_half
                 + $signed({7'b0, i_item.volume_trim, 2'b00})
                 - tcc_pkg::VOLUME_POT_OFFSET;
        priority if (i_item.muted || vol_raw[18]) begin
            vol_clamped = 12'd0;
        end else if (vol_raw > tcc_pkg::VOLUME_MAX) begin
            vol_clamped = 12'hFFF;
        end else begin
            vol_clamped = vol_raw[11:0];
        end
        vol_t    = vol_clamped[11:4];
        vol_t_p2 = {1'b0, vol_t} + 9'd2;
    end

    // result assembly
    always_comb begin
        o_result.advance_valid  = i_item.pitch_present && !i_item.muted;
        o_result.sample_advance = o_result.advance_valid
                                ? adv_shifted[tcc_pkg::ADV_W-1:0] : '0;
        o_result.volume_valid   = i_item.volume_present;
        o_result.scaled_volume  = i_item.volume_present
                                ? tcc_pkg::VOL_W'({8'b0, vol_t} * {7'b0, vol_t_p2}) : '0;
        o_result.wave_select    = n_wave_held[tcc_pkg::POT_W-1 -: tcc_pkg::WAVE_W];
        o_result.octave_code    = octave;
    end

    // state update when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_smoothed  <= '0;
            r_volume_smoothed <= '0;
            r_wave_held       <= '0;
        end else if (i_en) begin
            r_pitch_smoothed  <= n_pitch_smoothed;
            r_volume_smoothed <= n_volume_smoothed;
            r_wave_held       <= n_wave_held;
        end
    end

endmodule

### design/theremin_control_conditioner.sv
// top level of the theremin control conditioner
//
// Input channel i_valid / o_stall carries one control pass per item: four pot
// readings, optional pitch and volume capture counts and the mute flag.
// Output channel o_valid / i_stall carries exactly one result item per input
// item, in order. An item is taken at a clock edge with valid high and stall low.
// The item is captured in an input register, then the smoothers, hysteresis and
// volume arithmetic run in one pass and the result is captured in the result
// register, from which it is offered. One item per cycle is sustained while the
// receiver does not stall; the single pass between those two registers sets that
// figure. When the receiver stalls, the result register holds; the input register
// still takes one more item, and o_stall rises only when both registers are full.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// writes it only while idle, which the block does not enforce. Indexes beyond the
// four registers are ignored. Synchronous active-low reset empties both registers,
// zeroes the smoothers and the held wave pot, and loads the register defaults.
module theremin_control_conditioner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input items
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [tcc_pkg::POT_W-1:0]            i_pitch_trim,
    input  logic [tcc_pkg::POT_W-1:0]            i_volume_trim,
    input  logic [tcc_pkg::POT_W-1:0]            i_octave_pot,
    input  logic [tcc_pkg::POT_W-1:0]            i_wave_pot,
    input  logic                                 i_pitch_present,
    input  logic [tcc_pkg::COUNT_W-1:0]          i_pitch_count,
    input  logic                                 i_volume_present,
    input  logic [tcc_pkg::COUNT_W-1:0]          i_volume_count,
    input  logic                                 i_muted,
    // result items
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [tcc_pkg::ADV_W-1:0]     o_sample_advance,
    output logic                                 o_advance_valid,
    output logic [tcc_pkg::VOL_W-1:0]            o_scaled_volume,
    output logic                                 o_volume_valid,
    output logic [tcc_pkg::WAVE_W-1:0]           o_wave_select,
    output logic [tcc_pkg::OCT_W-1:0]            o_octave_code
);

    tcc_pkg::t_cfg    r_cfg;
    tcc_pkg::t_item   r_item;
    tcc_pkg::t_result r_result;
    tcc_pkg::t_result core_result;
    logic             r_in_full;
    logic             r_out_full;
    logic             advance;
    logic             in_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_base     <= '0;
            r_cfg.volume_base    <= '0;
            r_cfg.volume_ceiling <= tcc_pkg::CEILING_RESET;
            r_cfg.pot_hysteresis <= tcc_pkg::HYSTERESIS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcc_pkg::REG_PITCH_BASE: begin
                    r_cfg.pitch_base <= i_cfg_data;
                end
                tcc_pkg::REG_VOLUME_BASE: begin
                    r_cfg.volume_base <= i_cfg_data;
                end
                tcc_pkg::REG_VOLUME_CEILING: begin
                    r_cfg.volume_ceiling <= i_cfg_data[tcc_pkg::CEIL_W-1:0];
                end
                tcc_pkg::REG_POT_HYSTERESIS: begin
                    r_cfg.pot_hysteresis <= i_cfg_data[tcc_pkg::POT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshake: the computed item moves on when the result slot is free or leaving
    assign advance = r_in_full && (!r_out_full || !i_stall);
    assign o_stall = r_in_full && !advance;
    assign in_take = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
        end else if (in_take) begin
            r_in_full <= 1'b1;
        end else if (advance) begin
            r_in_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.pitch_trim     <= i_pitch_trim;
            r_item.volume_trim    <= i_volume_trim;
            r_item.octave_pot     <= i_octave_pot;
            r_item.wave_pot       <= i_wave_pot;
            r_item.pitch_present  <= i_pitch_present;
            r_item.pitch_count    <= i_pitch_count;
            r_item.volume_present <= i_volume_present;
            r_item.volume_count   <= i_volume_count;
            r_item.muted          <= i_muted;
        end
    end

    // arithmetic and state
    tcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (advance) begin
            r_out_full <= 1'b1;
        end else if (!i_stall) begin
            r_out_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    // outputs
    assign o_valid          = r_out_full;
    assign o_sample_advance = r_result.sample_advance;
    assign o_advance_valid  = r_result.advance_valid;
    assign o_scaled_volume  = r_result.scaled_volume;
    assign o_volume_valid   = r_result.volume_valid;
    assign o_wave_select    = r_result.wave_select;
    assign o_octave_code    = r_result.octave_code;

endmodule

### design/tcc_checker.sv
// port-level checks of the control conditioner and their binding
`include "theremin_control_conditioner_macros.svh"

module tcc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic signed [tcc_pkg::ADV_W-1:0] o_sample_advance,
    input logic                             o_advance_valid,
    input logic [tcc_pkg::VOL_W-1:0]        o_scaled_volume,
    input logic                             o_volume_valid,
    input logic [tcc_pkg::OCT_W-1:0]        o_octave_code
);

    // a stalled result stays on offer
    `TCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // no new pitch or muted: advance reads zero
    `TCC_ASSERT_NOW(a_adv_zero, i_clk, i_rst_n, o_valid && !o_advance_valid,
        o_sample_advance == '0)

    // no new volume: scaled volume reads zero
    `TCC_ASSERT_NOW(a_vol_zero, i_clk, i_rst_n, o_valid && !o_volume_valid,
        o_scaled_volume == '0)

    // octave code is a real shift amount
    `TCC_ASSERT_NOW(a_oct_code, i_clk, i_rst_n, o_valid,
        o_octave_code == tcc_pkg::OCT_UP || o_octave_code == tcc_pkg::OCT_CENTRE ||
        o_octave_code == tcc_pkg::OCT_DOWN)

endmodule

bind theremin_control_conditioner tcc_checker u_tcc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_sample_advance (o_sample_advance),
    .o_advance_valid  (o_advance_valid),
    .o_scaled_volume  (o_scaled_volume),
    .o_volume_valid   (o_volume_valid),
    .o_octave_code    (o_octave_code)
);

### tb/tb.sv
// self-checking testbench of the theremin control conditioner
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // expected result items of the control conditioner, worked out per accepted pass
    class pass_checker;
        tcc_pkg::t_cfg             regs;
        longint                    pitch_avg;
        longint                    vol_avg;
        logic [tcc_pkg::POT_W-1:0] wave_held;
        tcc_pkg::t_result          pending_results[$];
        int                        failures;
        int                        checked;

        function new();
            regs.pitch_base     = '0;
            regs.volume_base    = '0;
            regs.volume_ceiling = tcc_pkg::CEILING_RESET;
            regs.pot_hysteresis = tcc_pkg::HYSTERESIS_RESET;
            pitch_avg = 0;
            vol_avg   = 0;
            wave_held = '0;
            failures  = 0;
            checked   = 0;
        endfunction

        // register write, out-of-range indexes fall through
        function void write_reg(logic [tcc_pkg::CFG_IDX_W-1:0] idx,
                                logic [tcc_pkg::CFG_DATA_W-1:0] data);
            unique case (idx)
                tcc_pkg::REG_PITCH_BASE:     regs.pitch_base     = data;
                tcc_pkg::REG_VOLUME_BASE:    regs.volume_base    = data;
                tcc_pkg::REG_VOLUME_CEILING: regs.volume_ceiling = data[tcc_pkg::CEIL_W-1:0];
                tcc_pkg::REG_POT_HYSTERESIS: regs.pot_hysteresis = data[tcc_pkg::POT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint quarter_step(longint avg, longint sample);
            return avg + ((sample - avg) >>> 2);
        endfunction

        // advance the conditioner state by one pass and queue the result it gives
        function void note_pass(tcc_pkg::t_item it);
            tcc_pkg::t_result r;
            longint  diff;
            longint  adv;
            longint  vcount;
            longint  v;
            longint  t;
            r = '0;

            // wave pot hysteresis hold
            diff = longint'(it.wave_pot) - longint'(wave_held);
            if (diff < 0) diff = -diff;
            if (diff >= longint'(regs.pot_hysteresis)) wave_held = it.wave_pot;
            r.wave_select = tcc_pkg::WAVE_W'(wave_held >> (tcc_pkg::POT_W - tcc_pkg::WAVE_W));

            // octave code from the octave pot
            if (it.octave_pot > tcc_pkg::OCT_HIGH_THRESH) begin
                r.octave_code = tcc_pkg::OCT_UP;
            end else if (it.octave_pot < tcc_pkg::OCT_LOW_THRESH) begin
                r.octave_code = tcc_pkg::OCT_DOWN;
            end else begin
                r.octave_code = tcc_pkg::OCT_CENTRE;
            end

            // pitch smoother and sample advance, floor shift
            if (it.pitch_present) begin
                pitch_avg = quarter_step(pitch_avg, longint'(it.pitch_count));
                if (!it.muted) begin
                    adv = longint'(regs.pitch_base) - pitch_avg
                          + longint'(tcc_pkg::PITCH_OFFSET)
                          - 4 * longint'(it.pitch_trim);
                    adv = adv >>> r.octave_code;
                    r.sample_advance = adv[tcc_pkg::ADV_W-1:0];
                    r.advance_valid  = 1'b1;
                end
            end

            // volume floor, smoother, offset, clamp and t*(t+2) shaping
            if (it.volume_present) begin
                vcount = longint'(it.volume_count);
                if (vcount < longint'(tcc_pkg::VOLUME_FLOOR)) begin
                    vcount = longint'(tcc_pkg::VOLUME_FLOOR);
                end
                vol_avg = quarter_step(vol_avg, vcount);
                if (it.muted) begin
                    v = 0;
                end else begin
                    v = longint'(regs.volume_ceiling)
                        - (longint'(regs.volume_base) - vol_avg) / 2
                        + 4 * longint'(it.volume_trim)
                        - longint'(tcc_pkg::VOLUME_POT_OFFSET);
                end
                if (v > longint'(tcc_pkg::VOLUME_MAX)) v = longint'(tcc_pkg::VOLUME_MAX);
                if (v < 0) v = 0;
                t = v >> 4;
                r.scaled_volume = tcc_pkg::VOL_W'(t * (t + 2));
                r.volume_valid  = 1'b1;
            end

            pending_results.push_back(r);
        endfunction

        function void compare(string field, longint expd, longint got);
            if (got !== expd) begin
                $error("%s: expected %0d, got %0d", field, expd, got);
                failures++;
            end
        endfunction

        // match one accepted result item against the oldest expectation
        function void check_result(tcc_pkg::t_result got);
            tcc_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $error("result item arrived with no control pass waiting");
                failures++;
                return;
            end
            want = pending_results.pop_front();
            compare("sample_advance", longint'(want.sample_advance),
                    longint'(got.sample_advance));
            compare("advance_valid", longint'(want.advance_valid),
                    longint'(got.advance_valid));
            compare("scaled_volume", longint'(want.scaled_volume),
                    longint'(got.scaled_volume));
            compare("volume_valid", longint'(want.volume_valid), longint'(got.volume_valid));
            compare("wave_select", longint'(want.wave_select), longint'(got.wave_select));
            compare("octave_code", longint'(want.octave_code), longint'(got.octave_code));
            checked++;
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n          = 1'b0;
    logic                                 i_cfg_we         = 1'b0;
    logic [tcc_pkg::CFG_IDX_W-1:0]        i_cfg_index      = '0;
    logic [tcc_pkg::CFG_DATA_W-1:0]       i_cfg_data       = '0;
    logic                                 i_valid          = 1'b0;
    logic                                 o_stall;
    logic [tcc_pkg::POT_W-1:0]            i_pitch_trim     = '0;
    logic [tcc_pkg::POT_W-1:0]            i_volume_trim    = '0;
    logic [tcc_pkg::POT_W-1:0]            i_octave_pot     = '0;
    logic [tcc_pkg::POT_W-1:0]            i_wave_pot       = '0;
    logic                                 i_pitch_present  = 1'b0;
    logic [tcc_pkg::COUNT_W-1:0]          i_pitch_count    = '0;
    logic                                 i_volume_present = 1'b0;
    logic [tcc_pkg::COUNT_W-1:0]          i_volume_count   = '0;
    logic                                 i_muted          = 1'b0;
    logic                                 o_valid;
    logic                                 i_stall          = 1'b0;
    logic signed [tcc_pkg::ADV_W-1:0]     o_sample_advance;
    logic                                 o_advance_valid;
    logic [tcc_pkg::VOL_W-1:0]            o_scaled_volume;
    logic                                 o_volume_valid;
    logic [tcc_pkg::WAVE_W-1:0]           o_wave_select;
    logic [tcc_pkg::OCT_W-1:0]            o_octave_code;

    pass_checker      board = new();
    tcc_pkg::t_result seen;
    int               held_off     = 0;
    int               burst_left   = 0;
    bit               gaps_on      = 1'b0;
    bit               stall_on     = 1'b0;
    bit               hold_request = 1'b0;

    theremin_control_conditioner DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    // receiver: alternating stall and release runs, plus one long hold-off on request
    initial begin
        int  run_left;
        bit  stalling;
        run_left = 0;
        stalling = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 4) : $urandom_range(1, 9);
                end
                run_left--;
                i_stall <= stall_on && stalling;
            end
        end
    end

    // result monitor, sampled mid-cycle where all signals are settled
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen.sample_advance = o_sample_advance;
            seen.advance_valid  = o_advance_valid;
            seen.scaled_volume  = o_scaled_volume;
            seen.volume_valid   = o_volume_valid;
            seen.wave_select    = o_wave_select;
            seen.octave_code    = o_octave_code;
            board.check_result(seen);
        end
        if (i_rst_n && i_valid && o_stall) held_off++;
    end

    function automatic tcc_pkg::t_item control_pass(int pp, int vp, int op, int wp, bit pv,
                                                    int pc, bit vv, int vc, bit m);
        tcc_pkg::t_item it;
        it.pitch_trim     = tcc_pkg::POT_W'(pp);
        it.volume_trim    = tcc_pkg::POT_W'(vp);
        it.octave_pot     = tcc_pkg::POT_W'(op);
        it.wave_pot       = tcc_pkg::POT_W'(wp);
        it.pitch_present  = pv;
        it.pitch_count    = tcc_pkg::COUNT_W'(pc);
        it.volume_present = vv;
        it.volume_count   = tcc_pkg::COUNT_W'(vc);
        it.muted          = m;
        return it;
    endfunction

    function automatic int clamp_near(int centre, int below, int above, int top);
        int v;
        v = centre - int'($urandom_range(0, below)) + int'($urandom_range(0, above));
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v;
    endfunction

    // random control pass, counts mostly near the calibrated bases as a moving hand gives
    function automatic tcc_pkg::t_item random_pass();
        tcc_pkg::t_item it;
        int             hyst;
        hyst = int'(board.regs.pot_hysteresis);
        it.pitch_trim  = tcc_pkg::POT_W'($urandom);
        it.volume_trim = tcc_pkg::POT_W'($urandom);
        it.octave_pot  = tcc_pkg::POT_W'($urandom);
        // wave pot hovers around the held reading so the hysteresis edge comes up often
        if ($urandom_range(0, 2) == 0) begin
            it.wave_pot = tcc_pkg::POT_W'($urandom);
        end else begin
            it.wave_pot = tcc_pkg::POT_W'(clamp_near(int'(board.wave_held), hyst + 2,
                                                     hyst + 2, 1023));
        end
        it.pitch_present = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) begin
            it.pitch_count = tcc_pkg::COUNT_W'($urandom);
        end else begin
            it.pitch_count = tcc_pkg::COUNT_W'(clamp_near(int'(board.regs.pitch_base),
                                                          3000, 3000, 65535));
        end
        it.volume_present = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) begin
            it.volume_count = tcc_pkg::COUNT_W'($urandom);
        end else begin
            it.volume_count = tcc_pkg::COUNT_W'(clamp_near(int'(board.regs.volume_base),
                                                           14000, 1000, 65535));
        end
        it.muted = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    task automatic drive_pass(tcc_pkg::t_item it);
        i_pitch_trim     <= it.pitch_trim;
        i_volume_trim    <= it.volume_trim;
        i_octave_pot     <= it.octave_pot;
        i_wave_pot       <= it.wave_pot;
        i_pitch_present  <= it.pitch_present;
        i_pitch_count    <= it.pitch_count;
        i_volume_present <= it.volume_present;
        i_volume_count   <= it.volume_count;
        i_muted          <= it.muted;
    endtask

    // offer one item, idling between bursts if gaps are enabled, and hold it until taken
    task automatic offer_pass(tcc_pkg::t_item it);
        bit taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                i_valid <= 1'b0;
                drive_pass(random_pass());
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        drive_pass(it);
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        board.note_pass(it);
    endtask

    task automatic run_random(int count);
        repeat (count) offer_pass(random_pass());
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [tcc_pkg::CFG_IDX_W-1:0] idx,
                           logic [tcc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // write all four registers and one unused index, block idle
    task automatic configure(logic [tcc_pkg::CFG_DATA_W-1:0] pb,
                             logic [tcc_pkg::CFG_DATA_W-1:0] vb,
                             logic [tcc_pkg::CFG_DATA_W-1:0] ceil,
                             logic [tcc_pkg::CFG_DATA_W-1:0] hyst);
        logic [tcc_pkg::CFG_IDX_W-1:0] spare;
        spare = tcc_pkg::CFG_IDX_W'($urandom_range(int'(tcc_pkg::REG_POT_HYSTERESIS) + 1,
                                                   (1 << tcc_pkg::CFG_IDX_W) - 1));
        set_reg(tcc_pkg::REG_PITCH_BASE, pb);
        set_reg(tcc_pkg::REG_VOLUME_BASE, vb);
        set_reg(tcc_pkg::REG_VOLUME_CEILING, ceil);
        set_reg(tcc_pkg::REG_POT_HYSTERESIS, hyst);
        set_reg(spare, tcc_pkg::CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: field extremes, octave edges, volume floor, mute, hysteresis
        offer_pass(control_pass(0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_pass(control_pass(0, 0, 0, 0, 1, 0, 1, 0, 0));
        offer_pass(control_pass(1023, 1023, 341, 39, 1, 65535, 1, 4999, 0));
        offer_pass(control_pass(0, 0, 342, 40, 1, 65535, 1, 5000, 0));
        offer_pass(control_pass(1023, 1023, 681, 1023, 1, 65535, 1, 65535, 0));
        offer_pass(control_pass(512, 0, 682, 984, 1, 0, 1, 65535, 0));
        offer_pass(control_pass(700, 1023, 1023, 983, 1, 40000, 1, 30000, 0));
        offer_pass(control_pass(300, 300, 500, 500, 1, 20000, 1, 20000, 1));
        offer_pass(control_pass(300, 300, 500, 500, 0, 20000, 0, 20000, 1));
        offer_pass(control_pass(300, 300, 500, 500, 1, 30000, 0, 0, 1));
        offer_pass(control_pass(300, 300, 500, 500, 0, 0, 1, 7000, 1));
        offer_pass(control_pass(100, 800, 200, 0, 0, 0, 1, 12000, 0));
        offer_pass(control_pass(900, 50, 900, 1023, 1, 1, 0, 0, 0));
        drain();

        // calibrated bases in a typical range, both sides idling
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        configure(tcc_pkg::CFG_DATA_W'($urandom_range(20000, 60000)),
                  tcc_pkg::CFG_DATA_W'($urandom_range(15000, 50000)),
                  tcc_pkg::CFG_DATA_W'(tcc_pkg::CEILING_RESET),
                  tcc_pkg::CFG_DATA_W'(tcc_pkg::HYSTERESIS_RESET));
        run_random(140);
        drain();

        // top settings, receiver always ready
        stall_on = 1'b0;
        configure(16'hFFFF, 16'hFFFF, 16'h1FFF, 16'h03FF);
        offer_pass(control_pass(0, 1023, 1023, 1023, 1, 0, 1, 65535, 0));
        offer_pass(control_pass(1023, 0, 682, 0, 1, 65535, 1, 0, 0));
        offer_pass(control_pass(0, 1023, 1023, 1023, 1, 0, 1, 65535, 0));
        offer_pass(control_pass(0, 1023, 1023, 1023, 1, 0, 1, 65535, 1));
        run_random(100);
        drain();

        // bottom settings, zero threshold, sender never idle while the receiver holds off
        gaps_on      = 1'b0;
        stall_on     = 1'b1;
        configure('0, '0, '0, '0);
        hold_request = 1'b1;
        offer_pass(control_pass(0, 0, 0, 5, 1, 0, 1, 0, 0));
        offer_pass(control_pass(0, 0, 0, 5, 1, 0, 1, 0, 0));
        offer_pass(control_pass(1023, 1023, 341, 6, 1, 65535, 1, 65535, 0));
        offer_pass(control_pass(512, 512, 342, 0, 1, 12345, 1, 5000, 1));
        run_random(100);
        drain();

        // random register data including the upper bits, full idling
        gaps_on = 1'b1;
        configure(tcc_pkg::CFG_DATA_W'($urandom), tcc_pkg::CFG_DATA_W'($urandom),
                  tcc_pkg::CFG_DATA_W'($urandom), tcc_pkg::CFG_DATA_W'($urandom));
        run_random(160);
        drain();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d control passes checked over five register settings",
                 board.checked);
        $display("summary: input channel held off for %0d cycles", held_off);
        if (board.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/tcc_pkg.sv
design/tcc_core.sv
design/theremin_control_conditioner.sv
design/tcc_checker.sv
tb/tb.sv
